[hw/rtl/ghst_pkg.sv]
// Package for the generational handle slot table: status codes, command kinds.
// No dependencies.
`default_nettype none
package ghst_pkg;
  // table size; slot_index and live_entries ports are sized for 64 slots
  localparam int SLOTS = 64;

  localparam logic [1:0] KIND_GET     = 2'd0;
  localparam logic [1:0] KIND_RESOLVE = 2'd1;
  localparam logic [1:0] KIND_INVAL   = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_CREATED = 3'd1;
  localparam logic [2:0] ST_NO_VIEW = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture the input item
    logic scan_step; // examine slot at scan pointer
    logic finish;    // resolve the item and present result
  } ghst_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic scan_done; // scan finished: high-water mark, get hit, or resolve
  } ghst_stat_t;
endpackage
`default_nettype wire

[hw/rtl/ghst_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module ghst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/ghst_ctrl.sv]
// Controller state machine: sequences load, slot scan and finish.
// Depends on ghst_pkg.
`default_nettype none
module ghst_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire ghst_pkg::ghst_stat_t stat,
  output logic                      busy,
  output ghst_pkg::ghst_cmd_t       cmd
);
  import ghst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1; // slot memories read at scan pointer
  localparam logic [2:0] S_EV   = 3'd2; // examine the slot just read
  localparam logic [2:0] S_PRE  = 3'd3; // generation read for allocated slot
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (stat.scan_done) state_next = S_PRE;
        else state_next = S_EV;
      end
      S_EV: begin
        cmd.scan_step = 1'b1;
        state_next = S_RD;
      end
      S_PRE: state_next = S_FIN;
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_fin_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> $past(state) == S_PRE)
    else $error("finish without scan");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> busy)
    else $error("not busy after load");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("multiple commands");
endmodule
`default_nettype wire

[hw/rtl/ghst_dp.sv]
// Datapath: slot state, key match, free stack, allocation and release.
// Depends on ghst_pkg and ghst_ram. Keys, generations, views and the free
// stack sit in ghst_ram instances; each slot is read, then examined, in turn.
`default_nettype none
module ghst_dp #(
  parameter int VIEW_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ghst_pkg::ghst_cmd_t cmd,
  output ghst_pkg::ghst_stat_t     stat,
  input  wire logic [1:0]          kind,
  input  wire logic [63:0]         resource_id,
  input  wire logic [63:0]         desc_hash,
  input  wire logic [7:0]          heap_kind,
  input  wire logic                new_view_present,
  input  wire logic [63:0]         new_view,
  input  wire logic [31:0]         handle_index,
  input  wire logic [31:0]         handle_gen,
  output logic                     done,
  output logic [2:0]               status,
  output logic [5:0]               slot_index,
  output logic [31:0]              slot_gen,
  output logic [63:0]              view_out,
  output logic [6:0]               live_entries
);
  import ghst_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = 136;  // resource id, description hash, heap kind
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  logic [SLOTS-1:0] occupied;
  logic [SLOTS-1:0] gen_init;  // 1: generation still at reset value 1
  logic [CW-1:0]    free_count, high_water, live_count;

  // captured item
  logic [1:0]  r_kind;
  logic [63:0] r_rid, r_dh, r_view;
  logic [7:0]  r_hk;
  logic        r_present;
  logic [31:0] r_hidx, r_hgen;

  logic [CW-1:0] ptr;       // scan pointer
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [31:0]   hit_gen;

  // key, generation, view and free stack memories
  logic          key_we, gen_we, vw_we, fs_we;
  logic [IW-1:0] key_wa, gen_ra, vw_wa, vw_ra, fs_wa, fs_ra;
  logic [KW-1:0] key_rd;
  logic [31:0]   gen_rd, ginc;
  logic [VIEW_BITS-1:0] vw_rd;
  logic [IW-1:0] fs_rd;
  logic [IW-1:0] p;

  ghst_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_key (
    .clk, .we(key_we), .waddr(key_wa), .wdata({r_rid, r_dh, r_hk}),
    .raddr(p), .rdata(key_rd));
  ghst_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_gen (
    .clk, .we(gen_we), .waddr(p), .wdata(ginc),
    .raddr(gen_ra), .rdata(gen_rd));
  ghst_ram #(.WIDTH(VIEW_BITS), .DEPTH(SLOTS)) u_view (
    .clk, .we(vw_we), .waddr(vw_wa), .wdata(r_view[VIEW_BITS-1:0]),
    .raddr(vw_ra), .rdata(vw_rd));
  ghst_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_free (
    .clk, .we(fs_we), .waddr(fs_wa), .wdata(ptr[IW-1:0]),
    .raddr(fs_ra), .rdata(fs_rd));

  // key_rd and gen_rd hold slot p during a scan step
  logic [31:0]   gcur;
  logic          match, rel;
  assign p     = ptr[IW-1:0];
  assign gcur  = gen_init[p] ? 32'd1 : gen_rd;
  assign ginc  = (gcur == '1) ? 32'd1 : gcur + 32'd1;
  assign match = occupied[p] && key_rd[KW-1:KW-64] == r_rid &&
                 key_rd[KW-65:8] == r_dh && key_rd[7:0] == r_hk;
  assign rel   = (r_kind == KIND_CLEAR) ||
                 (r_kind == KIND_INVAL && occupied[p] && key_rd[KW-1:KW-64] == r_rid);

  // scan ends at high-water, or early for get on hit, or at once for resolve
  assign stat.scan_done = (ptr >= high_water) || (r_kind == KIND_RESOLVE) ||
                          (r_kind == KIND_GET && hit);

  assign gen_we = cmd.scan_step && rel;
  assign fs_we = cmd.scan_step && rel && free_count < SLOTS_C;
  assign fs_wa = free_count[IW-1:0];
  assign fs_ra = IW'(free_count - CW'(1));
  assign vw_ra = r_hidx[IW-1:0];

  // allocation decision at finish
  logic          alloc_free, alloc_new, do_alloc;
  logic [IW-1:0] aslot, ridx;
  logic          rok;
  assign alloc_free = free_count != '0;
  assign alloc_new  = !alloc_free && high_water < SLOTS_C;
  assign do_alloc   = cmd.finish && r_kind == KIND_GET && !hit && r_present
                      && (alloc_free || alloc_new);
  assign aslot  = alloc_free ? fs_rd : high_water[IW-1:0];
  assign key_we = do_alloc;
  assign key_wa = aslot;
  assign vw_we  = do_alloc;
  assign vw_wa  = aslot;
  assign ridx   = r_hidx[IW-1:0];
  // generation port: handle slot on resolve, scan slot, then allocated slot
  assign gen_ra = (r_kind == KIND_RESOLVE) ? ridx :
                  (stat.scan_done ? aslot : p);
  assign rok    = r_hgen != '0 && r_hidx < 32'(high_water) &&
                  occupied[ridx] &&
                  (gen_init[ridx] ? 32'd1 : gen_rd) == r_hgen;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_kind <= kind; r_rid <= resource_id; r_dh <= desc_hash;
      r_hk <= heap_kind; r_present <= new_view_present; r_view <= new_view;
      r_hidx <= handle_index; r_hgen <= handle_gen;
    end
    if (cmd.scan_step && r_kind == KIND_GET && match) begin
      hit_idx <= p;
      hit_gen <= gcur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0; gen_init <= '1;
      free_count <= '0; high_water <= '0; live_count <= '0;
      ptr <= '0; hit <= 1'b0; done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        ptr <= '0; hit <= 1'b0;
        if (kind == KIND_CLEAR) free_count <= '0;
      end
      if (cmd.scan_step) begin
        ptr <= ptr + CW'(1);
        if (r_kind == KIND_GET && match) hit <= 1'b1;
        if (rel) begin
          occupied[p] <= 1'b0;
          gen_init[p] <= 1'b0;
          if (free_count < SLOTS_C) free_count <= free_count + CW'(1);
          if (r_kind == KIND_INVAL && live_count != '0)
            live_count <= live_count - CW'(1);
        end
      end
      if (cmd.finish && r_kind == KIND_CLEAR) live_count <= '0;
      if (do_alloc) begin
        occupied[aslot] <= 1'b1;
        live_count <= live_count + CW'(1);
        if (alloc_free) free_count <= free_count - CW'(1);
        else high_water <= high_water + CW'(1);
      end
    end
  end

  // result registers
  logic [6:0] live_next;
  assign live_next = do_alloc ? 7'(live_count + CW'(1)) :
                     (r_kind == KIND_CLEAR ? 7'd0 : 7'(live_count));
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= ST_DONE; slot_index <= '0; slot_gen <= '0; view_out <= '0;
      live_entries <= live_next;
      unique case (r_kind)
        KIND_GET: begin
          if (hit) begin
            status <= ST_HIT; slot_index <= 6'(hit_idx);
            slot_gen <= hit_gen;
          end else if (!r_present) status <= ST_NO_VIEW;
          else if (do_alloc) begin
            status <= ST_CREATED; slot_index <= 6'(aslot);
            slot_gen <= gen_init[aslot] ? 32'd1 : gen_rd;
          end else status <= ST_FULL;
        end
        KIND_RESOLVE: begin
          if (rok) begin
            status <= ST_HIT; slot_index <= 6'(ridx); slot_gen <= r_hgen;
            view_out <= 64'(vw_rd);
          end else status <= ST_INVALID;
        end
        default: ;
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= high_water) else $error("live above high-water");
  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    high_water <= SLOTS_C) else $error("high-water overflow");
  a_alloc_live: assert property (@(posedge clk) disable iff (rst)
    do_alloc |=> live_count == $past(live_count) + CW'(1))
    else $error("alloc count");
endmodule
`default_nettype wire

[hw/rtl/generational_handle_slot_table.sv]
// Top level of the generational handle slot table.
// Depends on ghst_pkg, ghst_ctrl, ghst_dp, ghst_ram.
`default_nettype none
// Command-style slot table of 64 slots. Pulse start while busy is low; one
// result per transfer appears with done high for exactly one cycle and cannot
// be stalled. After start is taken the controller passes S_RD, then S_EV and
// S_RD again for each slot scanned, then S_PRE and S_FIN; done is registered
// from S_FIN. Resolve scans no slot; each scanned slot takes a memory read
// state and a compare state. Invalidate, clear and a get miss scan up to the
// high-water mark; a get hit stops at the matching slot. busy drops in the
// cycle done is high, so the next item can be taken there. No clearing pass
// after reset: a per-slot flag makes unwritten generations read as 1, and the
// block is ready the cycle after rst drops.
module generational_handle_slot_table #(
  parameter int VIEW_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [63:0] resource_id,
  input  wire logic [63:0] desc_hash,
  input  wire logic [7:0]  heap_kind,
  input  wire logic        new_view_present,
  input  wire logic [63:0] new_view,
  input  wire logic [31:0] handle_index,
  input  wire logic [31:0] handle_gen,
  output logic             done,
  output logic [2:0]       status,
  output logic [5:0]       slot_index,
  output logic [31:0]      slot_gen,
  output logic [63:0]      view_out,
  output logic [6:0]       live_entries
);
  import ghst_pkg::*;

  ghst_cmd_t  cmd;
  ghst_stat_t stat;

  ghst_ctrl u_ctrl (.clk, .rst, .start, .stat, .busy, .cmd);

  ghst_dp #(.VIEW_BITS(VIEW_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .kind, .resource_id, .desc_hash, .heap_kind,
    .new_view_present, .new_view, .handle_index, .handle_gen, .done, .status,
    .slot_index, .slot_gen, .view_out, .live_entries);
endmodule
`default_nettype wire
